>>> hw/rtl/smm_pkg.sv
// Shared types, constants and helpers for the soft-switch memory mapper.
package smm_pkg;

  localparam int unsigned PhysW = 18;

  localparam logic [PhysW-1:0] RomDBase    = 18'h21000;
  localparam logic [PhysW-1:0] RomEfBase   = 18'h22000;
  localparam logic [PhysW-1:0] IntSlotBase = 18'h20100;
  localparam logic [PhysW-1:0] ExtSlotBase = 18'h24000;
  localparam logic [PhysW-1:0] IntC8Base   = 18'h20800;
  localparam logic [7:0]       FlagBit     = 8'h80;

  typedef enum logic [1:0] {
    TGT_RAM = 2'd0,
    TGT_ROM = 2'd1,
    TGT_IO  = 2'd2,
    TGT_IGN = 2'd3
  } target_e;

  // C0xx group select, address bits 7:4
  localparam logic [3:0] GRP_KEY    = 4'h0;
  localparam logic [3:0] GRP_STATUS = 4'h1;
  localparam logic [3:0] GRP_VIDEO  = 4'h5;
  localparam logic [3:0] GRP_LC     = 4'h8;

  // C00x write switch index, address bits 3:1
  localparam logic [2:0] SW_STORE80   = 3'd0;
  localparam logic [2:0] SW_AUX_READ  = 3'd1;
  localparam logic [2:0] SW_AUX_WRITE = 3'd2;
  localparam logic [2:0] SW_INT_SLOT  = 3'd3;
  localparam logic [2:0] SW_ALT_ZP    = 3'd4;
  localparam logic [2:0] SW_SLOT3     = 3'd5;
  localparam logic [2:0] SW_COL80     = 3'd6;
  localparam logic [2:0] SW_ALT_CHAR  = 3'd7;

  // C01x read status index, address bits 3:0
  localparam logic [3:0] ST_KEY_FLAG  = 4'h0;
  localparam logic [3:0] ST_LC_BANK2  = 4'h1;
  localparam logic [3:0] ST_LC_RAM    = 4'h2;
  localparam logic [3:0] ST_AUX_READ  = 4'h3;
  localparam logic [3:0] ST_AUX_WRITE = 4'h4;
  localparam logic [3:0] ST_INT_SLOT  = 4'h5;
  localparam logic [3:0] ST_ALT_ZP    = 4'h6;
  localparam logic [3:0] ST_SLOT3     = 4'h7;
  localparam logic [3:0] ST_STORE80   = 4'h8;
  localparam logic [3:0] ST_VBLANK    = 4'h9;
  localparam logic [3:0] ST_TEXT      = 4'hA;
  localparam logic [3:0] ST_MIXED     = 4'hB;
  localparam logic [3:0] ST_PAGE2     = 4'hC;
  localparam logic [3:0] ST_HIRES     = 4'hD;
  localparam logic [3:0] ST_ALT_CHAR  = 4'hE;
  localparam logic [3:0] ST_COL80     = 4'hF;

  typedef struct packed {
    logic       store80;
    logic       aux_read;
    logic       aux_write;
    logic       internal_slot_rom;
    logic       alt_zero_page;
    logic       slot3_rom;
    logic       col80;
    logic       alt_charset;
    logic [3:0] video;  // bit0 text, bit1 mixed, bit2 page2, bit3 hires
    logic       lc_read_ram;
    logic       lc_read_bank2;
    logic       lc_write_enable;
    logic       lc_write_bank2;
  } mmu_state_t;

  typedef struct packed {
    logic [7:0]       read_data;
    target_e          target;
    logic [PhysW-1:0] phys;
    logic             strobe;
  } result_t;

  function automatic logic [7:0] flag_byte(input logic f);
    return f ? FlagBit : 8'h00;
  endfunction

endpackage

>>> hw/rtl/smm_decode.sv
// Address decode, soft-switch update and physical address translation for one beat.
module smm_decode (
  input  smm_pkg::mmu_state_t st_i,
  input  logic                mode_i,
  input  logic [15:0]         address_i,
  input  logic [7:0]          key_data_i,
  input  logic [7:0]          key_flag_i,
  input  logic [7:0]          vblank_status_i,
  output smm_pkg::mmu_state_t st_o,
  output smm_pkg::result_t    res_o
);

  logic       wr;
  logic [3:0] grp;
  logic [3:0] sel;
  logic       b2;
  logic       aux;
  logic [15:0] lc_addr;

  assign wr  = mode_i;
  assign grp = address_i[7:4];
  assign sel = address_i[3:0];
  assign b2  = ~sel[3];

  always_comb begin
    st_o          = st_i;
    res_o         = '0;
    res_o.target  = smm_pkg::TGT_RAM;
    aux           = 1'b0;
    lc_addr       = address_i;

    if (address_i < 16'h0200) begin
      res_o.phys = {1'b0, st_i.alt_zero_page, address_i};
    end else if (address_i < 16'hC000) begin
      aux        = wr ? st_i.aux_write : st_i.aux_read;
      res_o.phys = {1'b0, aux, address_i};
    end else if (address_i < 16'hC100) begin
      res_o.target = smm_pkg::TGT_IO;
      unique case (grp)
        smm_pkg::GRP_KEY: begin
          if (wr) begin
            unique case (sel[3:1])
              smm_pkg::SW_STORE80:   st_o.store80           = sel[0];
              smm_pkg::SW_AUX_READ:  st_o.aux_read          = sel[0];
              smm_pkg::SW_AUX_WRITE: st_o.aux_write         = sel[0];
              smm_pkg::SW_INT_SLOT:  st_o.internal_slot_rom = sel[0];
              smm_pkg::SW_ALT_ZP:    st_o.alt_zero_page     = sel[0];
              smm_pkg::SW_SLOT3:     st_o.slot3_rom         = sel[0];
              smm_pkg::SW_COL80:     st_o.col80             = sel[0];
              default:               st_o.alt_charset       = sel[0];
            endcase
          end else begin
            res_o.read_data = key_data_i;
          end
        end
        smm_pkg::GRP_STATUS: begin
          if (wr) begin
            res_o.strobe = 1'b1;
          end else begin
            res_o.strobe = (sel == smm_pkg::ST_KEY_FLAG);
            unique case (sel)
              smm_pkg::ST_KEY_FLAG:  res_o.read_data = key_flag_i;
              smm_pkg::ST_LC_BANK2:  res_o.read_data = smm_pkg::flag_byte(st_i.lc_read_bank2);
              smm_pkg::ST_LC_RAM:    res_o.read_data = smm_pkg::flag_byte(st_i.lc_read_ram);
              smm_pkg::ST_AUX_READ:  res_o.read_data = smm_pkg::flag_byte(st_i.aux_read);
              smm_pkg::ST_AUX_WRITE: res_o.read_data = smm_pkg::flag_byte(st_i.aux_write);
              smm_pkg::ST_INT_SLOT:
                res_o.read_data = smm_pkg::flag_byte(st_i.internal_slot_rom);
              smm_pkg::ST_ALT_ZP:    res_o.read_data = smm_pkg::flag_byte(st_i.alt_zero_page);
              smm_pkg::ST_SLOT3:     res_o.read_data = smm_pkg::flag_byte(st_i.slot3_rom);
              smm_pkg::ST_STORE80:   res_o.read_data = smm_pkg::flag_byte(st_i.store80);
              smm_pkg::ST_VBLANK:    res_o.read_data = vblank_status_i;
              smm_pkg::ST_TEXT:      res_o.read_data = smm_pkg::flag_byte(st_i.video[0]);
              smm_pkg::ST_MIXED:     res_o.read_data = smm_pkg::flag_byte(st_i.video[1]);
              smm_pkg::ST_PAGE2:     res_o.read_data = smm_pkg::flag_byte(st_i.video[2]);
              smm_pkg::ST_HIRES:     res_o.read_data = smm_pkg::flag_byte(st_i.video[3]);
              smm_pkg::ST_ALT_CHAR:  res_o.read_data = smm_pkg::flag_byte(st_i.alt_charset);
              default:               res_o.read_data = smm_pkg::flag_byte(st_i.col80);
            endcase
          end
        end
        smm_pkg::GRP_VIDEO: begin
          if (!sel[3]) begin
            st_o.video[sel[2:1]] = sel[0];
          end
        end
        smm_pkg::GRP_LC: begin
          if (sel[0]) begin
            st_o.lc_write_enable = 1'b1;
            st_o.lc_write_bank2  = b2;
          end else begin
            st_o.lc_write_enable = 1'b0;
          end
          if (sel[1:0] == 2'b00 || sel[1:0] == 2'b11) begin
            st_o.lc_read_ram   = 1'b1;
            st_o.lc_read_bank2 = b2;
          end else begin
            st_o.lc_read_ram   = 1'b0;
            st_o.lc_read_bank2 = 1'b0;
          end
        end
        default: ;
      endcase
    end else if (address_i < 16'hD000) begin
      if (wr) begin
        res_o.target = smm_pkg::TGT_IGN;
      end else begin
        res_o.target = smm_pkg::TGT_ROM;
        if (address_i < 16'hC800) begin
          res_o.phys = (st_i.internal_slot_rom ? smm_pkg::IntSlotBase : smm_pkg::ExtSlotBase)
                       + {6'b0, address_i[11:0]} - 18'h00100;
        end else begin
          res_o.phys = smm_pkg::IntC8Base + {7'b0, address_i[10:0]};
        end
      end
    end else if (address_i < 16'hE000) begin
      if (wr) begin
        if (st_i.lc_write_enable) begin
          lc_addr    = st_i.lc_write_bank2 ? address_i : address_i - 16'h1000;
          res_o.phys = {1'b0, st_i.alt_zero_page, lc_addr};
        end else begin
          res_o.target = smm_pkg::TGT_IGN;
        end
      end else begin
        if (st_i.lc_read_ram) begin
          lc_addr    = st_i.lc_read_bank2 ? address_i : address_i - 16'h1000;
          res_o.phys = {1'b0, st_i.alt_zero_page, lc_addr};
        end else begin
          res_o.target = smm_pkg::TGT_ROM;
          res_o.phys   = smm_pkg::RomDBase + {6'b0, address_i[11:0]};
        end
      end
    end else begin
      if (wr ? st_i.lc_write_enable : st_i.lc_read_ram) begin
        res_o.phys = {1'b0, st_i.alt_zero_page, address_i};
      end else if (wr) begin
        res_o.target = smm_pkg::TGT_IGN;
      end else begin
        res_o.target = smm_pkg::TGT_ROM;
        res_o.phys   = smm_pkg::RomEfBase + {5'b0, address_i[12:0]};
      end
    end
  end

endmodule

>>> hw/rtl/softswitch_memory_mapper.sv
// Top level of the soft-switch memory mapper: input register, decode, result register.
// Each bus access beat is captured in an input register, decoded against the current
// soft-switch and language-card flags, and moves into the result register once the
// result side can take it. One beat is taken every cycle unless the input side stalls;
// the flag registers are updated as a beat moves from the input register
// to the result register, so back-to-back beats see each other's switch effects in
// order. The input side stalls only while both registers are full and the result side
// stalls. No clearing pass after reset: all flags reset to zero at once.
module softswitch_memory_mapper (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  key_data_i,
  input  logic [7:0]  key_flag_i,
  input  logic [7:0]  vblank_status_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  read_data_o,
  output logic [1:0]  target_o,
  output logic [17:0] physical_address_o,
  output logic        strobe_clear_o
);

  logic                s1_valid_q;
  logic                mode_q;
  logic [15:0]         address_q;
  logic [7:0]          key_data_q;
  logic [7:0]          key_flag_q;
  logic [7:0]          vblank_q;
  smm_pkg::mmu_state_t st_q;
  smm_pkg::mmu_state_t st_d;
  smm_pkg::result_t    res_d;
  smm_pkg::result_t    res_q;
  logic                out_valid_q;
  logic                out_free;
  logic                s1_fire;
  logic                in_fire;

  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign s1_fire    = s1_valid_q & out_free;
  assign in_stall_o = s1_valid_q & ~out_free;
  assign in_fire    = in_valid_i & ~in_stall_o;

  smm_decode u_decode (
    .st_i            (st_q),
    .mode_i          (mode_q),
    .address_i       (address_q),
    .key_data_i      (key_data_q),
    .key_flag_i      (key_flag_q),
    .vblank_status_i (vblank_q),
    .st_o            (st_d),
    .res_o           (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
        st_q        <= st_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q     <= mode_i;
      address_q  <= address_i;
      key_data_q <= key_data_i;
      key_flag_q <= key_flag_i;
      vblank_q   <= vblank_status_i;
    end
    if (s1_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign read_data_o        = res_q.read_data;
  assign target_o           = res_q.target;
  assign physical_address_o = res_q.phys;
  assign strobe_clear_o     = res_q.strobe;

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a full pipeline");

  a_fire_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_q)
    else $error("decoded beat not presented");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_fire |=> $stable(st_q))
    else $error("flags changed without a beat");

  a_io_phys: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (res_q.target == smm_pkg::TGT_IO || res_q.target == smm_pkg::TGT_IGN))
      |-> (res_q.phys == '0))
    else $error("nonzero address on I/O or ignored beat");

  a_strobe_io: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.strobe) |-> (res_q.target == smm_pkg::TGT_IO))
    else $error("strobe on non-I/O beat");

endmodule
